@@ sv/hsr_pkg.sv @@
// Shared types and constants of the Heron square root core.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hsr_pkg;

    localparam int IN_W    = 32;
    localparam int ROOT_W  = 24;
    localparam int STEPS_W = 7;
    localparam int TOL_W   = 32;
    localparam int CFG_AW  = 3;

    localparam logic [ROOT_W-1:0] ROOT_MAX  = 24'hFFFFFF;
    localparam logic [TOL_W-1:0]  TOL_RESET = 32'd66;

    // register index, taken from paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;

    typedef struct packed {
        logic load_in;
        logic isq_step;
        logic init_x;
        logic square;
        logic diff;
        logic div_start;
        logic div_step;
        logic update;
        logic load_out;
    } hsr_cmd_t;

    typedef struct packed {
        logic isq_last;
        logic within_tol;
        logic steps_max;
        logic div_last;
        logic out_free;
    } hsr_status_t;

endpackage

`default_nettype wire

@@ sv/hsr_ctrl.sv @@
// Sequencer of the Heron square root core: start root, check, divide, update.
// Depends on hsr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hsr_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  hsr_pkg::hsr_status_t status,
    output hsr_pkg::hsr_cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ISQ  = 4'd1;
    localparam logic [3:0] ST_INIT = 4'd2;
    localparam logic [3:0] ST_SQ   = 4'd3;
    localparam logic [3:0] ST_CMP  = 4'd4;
    localparam logic [3:0] ST_TEST = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_ISQ;
                end
            end
            ST_ISQ: begin
                cmd.isq_step = 1'b1;
                if (status.isq_last) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init_x = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.square = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.diff   = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (status.within_tol || status.steps_max) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_SQ;
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hsr_datapath.sv @@
// Datapath of the Heron square root core: start root search, squaring unit,
// error compare, radix-2 restoring divider and output register.
// Depends on hsr_pkg; driven by hsr_ctrl through hsr_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module hsr_datapath #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_ITER  = 32
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  hsr_pkg::hsr_cmd_t              cmd,
    output hsr_pkg::hsr_status_t           status,
    input  wire [hsr_pkg::IN_W-1:0]        radicand,
    input  wire [hsr_pkg::TOL_W-1:0]       tolerance,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [31:0]                    m_tdata,
    output logic [0:0]                     m_tuser
);

    localparam int NW   = hsr_pkg::IN_W - FRAC_BITS;
    localparam int RW   = (NW + 1) / 2;
    localparam int BW   = $clog2(RW);
    localparam int XW   = (hsr_pkg::IN_W + FRAC_BITS) / 2 + 2;
    localparam int SQW  = 2 * XW;
    localparam int AW   = hsr_pkg::IN_W + FRAC_BITS;
    localparam int CNTW = $clog2(AW);
    localparam int SW   = $clog2(MAX_ITER + 1);
    localparam int RXW  = (XW > hsr_pkg::ROOT_W) ? XW : hsr_pkg::ROOT_W;

    logic [hsr_pkg::IN_W-1:0] a_reg;
    logic [RW-1:0]            r_reg;
    logic [BW-1:0]            b_reg;
    logic [XW-1:0]            x_reg;
    logic [SQW-1:0]           sq_reg;
    logic [SQW-1:0]           err_reg;
    logic [AW-1:0]            dvd_reg;
    logic [XW-1:0]            d_reg;
    logic [XW:0]              rem_reg;
    logic [XW-1:0]            q_reg;
    logic [CNTW-1:0]          cnt_reg;
    logic [SW-1:0]            steps_reg;

    logic                         m_valid_reg;
    logic [hsr_pkg::ROOT_W-1:0]   root_out_reg;
    logic [hsr_pkg::STEPS_W-1:0]  steps_out_reg;
    logic                         conv_out_reg;

    // start root: one bit per cycle, trial squared against the integer part
    logic [NW-1:0]   int_part;
    logic [RW-1:0]   trial;
    logic [2*RW-1:0] trial_sq;
    logic            trial_ok;

    assign int_part = a_reg[hsr_pkg::IN_W-1:FRAC_BITS];
    assign trial    = r_reg | (RW'(1) << b_reg);
    assign trial_sq = (2*RW)'(trial) * (2*RW)'(trial);
    assign trial_ok = (trial_sq <= (2*RW)'(int_part));

    logic [XW-1:0]  x_start;
    logic [SQW-1:0] a_wide;
    logic [SQW-1:0] tol_wide;

    assign x_start  = XW'(r_reg) << FRAC_BITS;
    assign a_wide   = SQW'(a_reg) << FRAC_BITS;
    assign tol_wide = SQW'(tolerance) << FRAC_BITS;

    // divider step
    logic [XW:0] rem_sh;
    logic        q_bit;

    assign rem_sh = {rem_reg[XW-1:0], dvd_reg[AW-1]};
    assign q_bit  = (rem_sh >= {1'b0, d_reg});

    logic [XW:0]    x_sum;
    logic [RXW-1:0] x_ext;

    assign x_sum = (XW+1)'(x_reg) + (XW+1)'(q_reg);
    assign x_ext = RXW'(x_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_reg <= radicand;
            r_reg <= '0;
            b_reg <= BW'(RW - 1);
        end
        if (cmd.isq_step) begin
            if (trial_ok) begin
                r_reg <= trial;
            end
            b_reg <= b_reg - BW'(1);
        end
        if (cmd.init_x) begin
            steps_reg <= '0;
            if ((r_reg == '0) && (a_reg != '0)) begin
                x_reg <= XW'(1) << FRAC_BITS;
            end else begin
                x_reg <= x_start;
            end
        end
        if (cmd.square) begin
            sq_reg <= SQW'(x_reg) * SQW'(x_reg);
        end
        if (cmd.diff) begin
            err_reg <= (sq_reg >= a_wide) ? (sq_reg - a_wide) : (a_wide - sq_reg);
        end
        if (cmd.div_start) begin
            dvd_reg <= AW'(a_reg) << FRAC_BITS;
            d_reg   <= (x_reg == '0) ? XW'(1) : x_reg;
            rem_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= CNTW'(AW - 1);
        end
        if (cmd.div_step) begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, d_reg}) : rem_sh;
            q_reg   <= {q_reg[XW-2:0], q_bit};
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg - CNTW'(1);
        end
        if (cmd.update) begin
            x_reg     <= x_sum[XW:1];
            steps_reg <= steps_reg + SW'(1);
        end
        if (cmd.load_out) begin
            root_out_reg  <= (x_ext > RXW'(hsr_pkg::ROOT_MAX)) ? hsr_pkg::ROOT_MAX
                                                               : x_ext[hsr_pkg::ROOT_W-1:0];
            steps_out_reg <= hsr_pkg::STEPS_W'(steps_reg);
            conv_out_reg  <= status.within_tol;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.isq_last   = (b_reg == '0);
    assign status.within_tol = (err_reg <= tol_wide);
    assign status.steps_max  = (steps_reg >= SW'(MAX_ITER));
    assign status.div_last   = (cnt_reg == '0);
    assign status.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, steps_out_reg, root_out_reg};
    assign m_tuser  = conv_out_reg;

endmodule

`default_nettype wire

@@ sv/heron_square_root_core.sv @@
// Top level of the Heron square root core: APB tolerance register,
// controller and datapath. Depends on hsr_pkg, hsr_ctrl and hsr_datapath.
//
//  channel  | direction | payload
//  s_       | in        | tdata[31:0] radicand UQ16.16
//  m_       | out       | tdata root, steps_taken; tuser converged
//  apb      | in/out    | tolerance at byte address 0
//
// Each request finds a start root of RW = (33 - FRAC_BITS)/2 bits, then takes k Heron steps,
// k = 0..MAX_ITER, each with a division over AW = 32 + FRAC_BITS dividend bits.
// The radix-2 divider, one quotient bit a cycle, dominates the time of a request.
// Synchronous active-low reset clears the sequencer and output valid, tolerance to 66.
// A result held by m_tready low stalls the next request only at its end.
`timescale 1ns / 1ps
`default_nettype none

module heron_square_root_core #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_ITER  = 32
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire [31:0]                  s_tdata,   // [31:0] radicand
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [31:0]                 m_tdata,   // [23:0] root, [30:24] steps_taken, [31] 0
    output logic [0:0]                  m_tuser,   // [0] converged
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [hsr_pkg::CFG_AW-1:0]   paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [hsr_pkg::TOL_W-1:0] tol_reg;
    hsr_pkg::hsr_cmd_t         cmd;
    hsr_pkg::hsr_status_t      status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= hsr_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == hsr_pkg::REG_TOLERANCE)) begin
            tol_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == hsr_pkg::REG_TOLERANCE) ? tol_reg : 32'd0;

    hsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hsr_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ITER  (MAX_ITER)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .radicand  (s_tdata),
        .tolerance (tol_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/hsr_checker.sv @@
// Port-level checks of the Heron square root core, bound to the top level.
// Depends only on the ports and the MAX_ITER parameter of heron_square_root_core.
`timescale 1ns / 1ps
`default_nettype none

module hsr_checker #(
    parameter int MAX_ITER = 32
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [0:0]  m_tuser
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new request taken while one is in work");

    a_cap_reached: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[30:24] == 7'(MAX_ITER)))
        else $error("not converged before step cap");

    a_steps_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:24] <= 7'(MAX_ITER)) && !m_tdata[31])
        else $error("step count out of range");

endmodule

bind heron_square_root_core hsr_checker #(
    .MAX_ITER (MAX_ITER)
) u_hsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
